### sv/i2cmbe_pkg.sv
package i2cmbe_pkg;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       with_start;
        logic       with_stop;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       slave_acked;
        logic [7:0] rx_byte;
    } result_t;

    typedef struct packed {
        logic       new_cmd;
        logic       stop_only;
        logic       rd;
        logic       with_start;
        logic       with_stop;
        logic       send_ack;
        logic [7:0] tx_byte;
        logic       sda_in;
    } cmd_t;

endpackage

### sv/i2cmbe_front.sv
module i2cmbe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  i2cmbe_pkg::item_t  item,
    input  logic               take,
    output logic               avail,
    output i2cmbe_pkg::cmd_t   cmd
);
    import i2cmbe_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;
    cmd_t       classified;

    // decode the command word once, on the way in
    always_comb
    begin
        classified            = '0;
        classified.new_cmd    = (item.op != OP_NONE);
        classified.stop_only  = (item.op == OP_STOP);
        classified.rd         = (item.op == OP_READ);
        classified.with_start = item.with_start;
        classified.with_stop  = item.with_stop;
        classified.send_ack   = item.send_ack;
        classified.tx_byte    = item.tx_byte;
        classified.sda_in     = item.sda_in;
    end

    assign full    = (cnt_reg == 2'd2);
    assign avail   = (cnt_reg != 2'd0);
    assign do_push = push && !full;
    assign do_pop  = take && avail;
    assign cmd     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

### sv/i2cmbe_engine.sv
module i2cmbe_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         phase_ticks,
    input  logic                take,
    input  i2cmbe_pkg::cmd_t    cmd,
    output i2cmbe_pkg::result_t res
);
    import i2cmbe_pkg::*;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_ST_A   = 4'd1;
    localparam logic [3:0] PH_ST_B   = 4'd2;
    localparam logic [3:0] PH_ST_C   = 4'd3;
    localparam logic [3:0] PH_BIT_LO = 4'd4;
    localparam logic [3:0] PH_BIT_HI = 4'd5;
    localparam logic [3:0] PH_SP_A   = 4'd6;
    localparam logic [3:0] PH_SP_B   = 4'd7;
    localparam logic [3:0] PH_SP_C   = 4'd8;

    typedef struct packed {
        logic rd;
        logic stop;
        logic ack;
        logic stop_only;
    } flags_t;

    function automatic logic data_bit(input logic [3:0] bi, input flags_t fl,
                                      input logic [7:0] sh);
        logic b;
        if (bi < 4'd8)
        begin
            b = fl.rd ? 1'b1 : sh[7];
        end
        else
        begin
            b = fl.rd ? ~fl.ack : 1'b1;
        end
        return b;
    endfunction

    // {scl, sda} on entry to a phase
    function automatic logic [1:0] phase_levels(input logic [3:0] p, input logic scl_now,
                                                input logic dbit, input logic [1:0] cur);
        logic [1:0] lv;
        lv = cur;
        unique case (p)
            PH_ST_A:   lv = 2'b11;
            PH_ST_B:   lv = 2'b10;
            PH_ST_C:   lv = 2'b00;
            PH_BIT_LO: lv = {scl_now, dbit};
            PH_BIT_HI: lv = {1'b1, dbit};
            PH_SP_A:   lv = {scl_now, 1'b0};
            PH_SP_B:   lv = 2'b10;
            PH_SP_C:   lv = 2'b11;
            default:   lv = cur;
        endcase
        return lv;
    endfunction

    logic [3:0]  phase_reg;
    logic [3:0]  phase_next;
    logic [15:0] tick_reg;
    logic [15:0] tick_next;
    logic [3:0]  bit_reg;
    logic [3:0]  bit_next;
    logic [7:0]  shift_reg;
    logic [7:0]  shift_next;
    flags_t      flags_reg;
    flags_t      flags_next;
    logic [1:0]  lines_reg;
    logic [1:0]  lines_next;
    logic        ack_reg;
    logic        ack_next;
    logic [15:0] limit;
    logic [1:0]  drive;
    logic        busy;
    logic        done;

    assign limit = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        flags_next = flags_reg;
        lines_next = lines_reg;
        ack_next   = ack_reg;
        done       = 1'b0;

        // command pick-up while idle
        if (phase_reg == PH_IDLE && cmd.new_cmd)
        begin
            bit_next  = 4'd0;
            ack_next  = 1'b0;
            tick_next = 16'd0;
            if (cmd.stop_only)
            begin
                flags_next = '{rd: 1'b0, stop: 1'b1, ack: 1'b0, stop_only: 1'b1};
                phase_next = PH_SP_A;
            end
            else
            begin
                flags_next = '{rd: cmd.rd, stop: cmd.with_stop, ack: cmd.send_ack,
                               stop_only: 1'b0};
                shift_next = cmd.rd ? 8'd0 : cmd.tx_byte;
                phase_next = cmd.with_start ? PH_ST_A : PH_BIT_LO;
            end
            lines_next = phase_levels(phase_next, lines_reg[1],
                                      data_bit(bit_next, flags_next, shift_next), lines_reg);
        end

        busy  = (phase_next != PH_IDLE);
        drive = lines_next;

        if (busy)
        begin
            tick_next = tick_next + 16'd1;
            if (tick_next >= limit)
            begin
                tick_next = 16'd0;
                unique case (phase_next)
                    PH_ST_A:   phase_next = PH_ST_B;
                    PH_ST_B:   phase_next = PH_ST_C;
                    PH_ST_C:   phase_next = PH_BIT_LO;
                    PH_BIT_LO: phase_next = PH_BIT_HI;
                    PH_BIT_HI:
                    begin
                        if (flags_next.rd)
                        begin
                            if (bit_next < 4'd8)
                            begin
                                shift_next = {shift_next[6:0], cmd.sda_in};
                            end
                        end
                        else if (bit_next < 4'd8)
                        begin
                            shift_next = {shift_next[6:0], 1'b0};
                        end
                        else
                        begin
                            ack_next = ~cmd.sda_in;
                        end
                        lines_next[1] = 1'b0;
                        bit_next      = bit_next + 4'd1;
                        if (bit_next <= 4'd8)
                        begin
                            phase_next = PH_BIT_LO;
                        end
                        else if (flags_next.stop)
                        begin
                            phase_next = PH_SP_A;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_SP_A:   phase_next = PH_SP_B;
                    PH_SP_B:   phase_next = PH_SP_C;
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
                if (!done)
                begin
                    lines_next = phase_levels(phase_next, lines_next[1],
                                              data_bit(bit_next, flags_next, shift_next),
                                              lines_next);
                end
            end
        end

        res             = '0;
        res.scl_out     = drive[1];
        res.sda_out     = drive[0];
        res.busy_res    = busy;
        res.done_res    = done;
        res.slave_acked = done && !flags_next.stop_only && !flags_next.rd && ack_next;
        res.rx_byte     = (done && !flags_next.stop_only && flags_next.rd) ? shift_next
                                                                           : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 16'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            flags_reg <= '0;
            lines_reg <= 2'b11;
            ack_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            flags_reg <= flags_next;
            lines_reg <= lines_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

### sv/i2cmbe_resq.sv
module i2cmbe_resq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  i2cmbe_pkg::result_t wr_data,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output i2cmbe_pkg::result_t result
);
    import i2cmbe_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_wr;
    logic       do_pop;

    assign full   = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign do_wr  = wr && !full;
    assign do_pop = pop && !empty;
    assign result = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= do_wr ? ~wr_ptr_reg : wr_ptr_reg;
            rd_ptr_reg <= do_pop ? ~rd_ptr_reg : rd_ptr_reg;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/i2c_master_byte_engine_unit.sv
// I2C master byte engine. Every input beat is one base tick of bus timing: it
// carries the sampled SDA level and, while the engine is idle, an optional
// command (write byte, read byte, lone stop, with optional start and stop).
// Every input beat yields exactly one result beat with the SCL/SDA drive for
// that tick, busy, a one-tick done pulse, the slave ack and the received byte.
// Input side: push/full with item. Result side: empty/pop with result, the
// oldest result is shown while empty is low. phase_ticks is written through
// cfg_valid/cfg_ready/cfg_data (ready is always high); the user must write it
// only while no tick is in flight; the block does not enforce it. It resets
// to 100 and zero acts as one. A pushed beat is decoded into a two-entry
// command queue, the bus engine takes it from there, and its result is written
// into the two-entry result queue as it is taken. The engine takes one tick per
// cycle, so with pop held high one beat is accepted every cycle.
// When the receiver stalls, the result queue fills, the engine stops, then
// the command queue fills and full rises; nothing is lost.
// Reset empties both queues and puts the bus idle with SCL and SDA released.
module i2c_master_byte_engine_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  i2cmbe_pkg::item_t   item,
    output logic                empty,
    input  logic                pop,
    output i2cmbe_pkg::result_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import i2cmbe_pkg::*;

    logic [15:0] phase_ticks_reg;
    logic        cmd_avail;
    logic        rq_full;
    logic        eng_take;
    cmd_t        cmd;
    result_t     eng_res;

    assign cfg_ready = 1'b1;
    assign eng_take  = cmd_avail && !rq_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            phase_ticks_reg <= cfg_data;
        end
    end

    i2cmbe_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .take  (eng_take),
        .avail (cmd_avail),
        .cmd   (cmd)
    );

    i2cmbe_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .phase_ticks (phase_ticks_reg),
        .take        (eng_take),
        .cmd         (cmd),
        .res         (eng_res)
    );

    i2cmbe_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (eng_take),
        .wr_data (eng_res),
        .full    (rq_full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.done_res) |-> result.busy_res)
        else $error("done without busy");

    a_ack_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.done_res) |-> (!result.slave_acked && result.rx_byte == 8'd0))
        else $error("ack or byte outside done");

    a_ack_xor_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.slave_acked) |-> (result.rx_byte == 8'd0))
        else $error("write ack and read byte together");

endmodule
